// ===== rtl/core/super_2x_sai_pixel_scaler_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the Super 2xSaI pixel scaler
// Concurrent checks compiled out when ASSERT_OFF is defined.
// ---------------------------------------------------------------------------
`ifndef SUPER_2X_SAI_PIXEL_SCALER_ASSERT_SVH
`define SUPER_2X_SAI_PIXEL_SCALER_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define SAI_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sai assertion failed");

// next-cycle implication
`define SAI_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sai assertion failed");

`else

`define SAI_ASSERT_SAME(name, clk, rst, ante, cons)

`define SAI_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/sai2x_pkg.sv =====
// ---------------------------------------------------------------------------
// sai2x_pkg
// Types, pixel-format masks and blend helpers for the 2xSaI scaler.
// ---------------------------------------------------------------------------
package sai2x_pkg;

   localparam int HIST_COLS = 3;

   localparam logic FMT_RGB565 = 1'b0;
   localparam logic FMT_RGB555 = 1'b1;

   localparam logic [1:0] FILL_ONE  = 2'd1;
   localparam logic [1:0] FILL_FULL = 2'd3;

   localparam logic [15:0] HALF_565 = 16'hF7DE;
   localparam logic [15:0] HALF_555 = 16'h7BDE;
   localparam logic [15:0] LOW_565  = 16'h0821;
   localparam logic [15:0] LOW_555  = 16'h0421;
   localparam logic [15:0] QTR_565  = 16'hE79C;
   localparam logic [15:0] QTR_555  = 16'h739C;
   localparam logic [15:0] QLOW_565 = 16'h1863;
   localparam logic [15:0] QLOW_555 = 16'h0C63;

   // one source column, above row in the low bits
   typedef struct packed {
      logic [15:0] below;
      logic [15:0] lower;
      logic [15:0] upper;
      logic [15:0] above;
   } column_type;

   // 2x2 output block, top-left in the low bits
   typedef struct packed {
      logic [15:0] bottom_right;
      logic [15:0] bottom_left;
      logic [15:0] top_right;
      logic [15:0] top_left;
   } quad_type;

   function automatic logic [15:0] avg2(input logic fmt, input logic [15:0] a,
                                        input logic [15:0] b);
      logic [15:0] mh;
      logic [15:0] ml;
      logic [16:0] sum;
      mh  = (fmt == FMT_RGB555) ? HALF_555 : HALF_565;
      ml  = (fmt == FMT_RGB555) ? LOW_555 : LOW_565;
      sum = {1'b0, (a & mh) >> 1} + {1'b0, (b & mh) >> 1} + {1'b0, a & b & ml};
      if (a == b) begin
         return a;
      end
      return sum[15:0];
   endfunction

   function automatic logic [15:0] avg4(input logic fmt, input logic [15:0] a,
                                        input logic [15:0] b, input logic [15:0] c,
                                        input logic [15:0] d);
      logic [15:0] mq;
      logic [15:0] ml;
      logic [17:0] hi;
      logic [17:0] lo;
      logic [17:0] res;
      mq  = (fmt == FMT_RGB555) ? QTR_555 : QTR_565;
      ml  = (fmt == FMT_RGB555) ? QLOW_555 : QLOW_565;
      hi  = {2'b00, (a & mq) >> 2} + {2'b00, (b & mq) >> 2}
          + {2'b00, (c & mq) >> 2} + {2'b00, (d & mq) >> 2};
      lo  = {2'b00, a & ml} + {2'b00, b & ml} + {2'b00, c & ml} + {2'b00, d & ml};
      res = hi + ((lo >> 2) & {2'b00, ml});
      return res[15:0];
   endfunction

   // +1, 0 or -1 depending on which of a/b matches c and d
   function automatic logic signed [1:0] vote(input logic [15:0] a, input logic [15:0] b,
                                              input logic [15:0] c, input logic [15:0] d);
      logic [1:0] x;
      logic [1:0] y;
      logic       px;
      logic       py;
      x = 2'd0;
      y = 2'd0;
      if (a == c) begin
         x = x + 2'd1;
      end else if (b == c) begin
         y = y + 2'd1;
      end
      if (a == d) begin
         x = x + 2'd1;
      end else if (b == d) begin
         y = y + 2'd1;
      end
      px = (x <= 2'd1);
      py = (y <= 2'd1);
      if (px && !py) begin
         return 2'sb01;
      end else if (!px && py) begin
         return 2'sb11;
      end
      return 2'sb00;
   endfunction

endpackage

// ===== rtl/core/super_2x_sai_pixel_scaler.sv =====
// ---------------------------------------------------------------------------
// super_2x_sai_pixel_scaler
// Super 2xSaI 2x scaler: column window in a row of cells, one block out.
//
//   port group   dir   payload
//   req_*        in    one 4-pixel source column, tuser = row start
//   rsp_*        out   2x2 output block for the window center
//   csr_*        in    pixel format (0 RGB565, 1 RGB555)
//
// One column word per cycle while the output does not stall; a block appears in
// the cycle after the column that completes its window, from the output register.
// After a row start the first three words fill the cell row and give no block.
// Reset clears fill count, format and output valid; window pixels are not reset.
// A stalled output holds; a new word is taken in the same cycle the output drains.
// ---------------------------------------------------------------------------
`include "super_2x_sai_pixel_scaler_assert.svh"

module super_2x_sai_pixel_scaler
   import sai2x_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // pix_above, pix_upper, pix_lower, pix_below
   input  logic [0:0]  req_tuser,   // row_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // out_top_left, out_top_right,
                                    // out_bottom_left, out_bottom_right
   input  logic        csr_we,
   input  logic        csr_wdata
);

   column_type new_col;
   column_type hist_col [HIST_COLS];
   column_type feed_col [HIST_COLS];
   quad_type   quad;
   quad_type   rsp_data_ff;
   quad_type   rsp_data_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic [1:0] fill_ff;
   logic [1:0] fill_in;
   logic       fmt_ff;
   logic       fmt_in;
   logic       accept;
   logic       full;

   assign new_col    = column_type'(req_tdata);
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign full       = !req_tuser[0] && (fill_ff == FILL_FULL);

   // cell i takes from cell i+1, the last cell from the incoming word
   for (genvar i = 0; i < HIST_COLS; i++) begin : g_cell
      if (i == HIST_COLS - 1) begin : g_last
         assign feed_col[i] = new_col;
      end else begin : g_mid
         assign feed_col[i] = hist_col[i + 1];
      end
      sai2x_col_cell u_cell (
         .clock    (clock),
         .shift    (accept),
         .next_col (feed_col[i]),
         .col_q    (hist_col[i])
      );
   end

   sai2x_kernel u_kernel (
      .fmt  (fmt_ff),
      .col0 (hist_col[0]),
      .col1 (hist_col[1]),
      .col2 (hist_col[2]),
      .col3 (new_col),
      .quad (quad)
   );

   always_comb begin
      fill_in      = fill_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      fmt_in       = csr_we ? csr_wdata : fmt_ff;
      if (accept) begin
         if (req_tuser[0]) begin
            fill_in = FILL_ONE;
         end else if (fill_ff != FILL_FULL) begin
            fill_in = fill_ff + 2'd1;
         end
         rsp_valid_in = full;
         if (full) begin
            rsp_data_in = quad;
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         fmt_ff       <= FMT_RGB565;
      end else begin
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         fmt_ff       <= fmt_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `SAI_ASSERT_NEXT(a_row_start_fill, clock, reset, accept && req_tuser[0], fill_ff == FILL_ONE)
   `SAI_ASSERT_NEXT(a_full_gives_word, clock, reset, accept && full, rsp_valid_ff)
   `SAI_ASSERT_SAME(a_stall_blocks_req, clock, reset, rsp_valid_ff && !rsp_tready, !req_tready)

endmodule

// ===== rtl/core/sai2x_col_cell.sv =====
// ---------------------------------------------------------------------------
// sai2x_col_cell
// One column of the sliding window; takes its neighbor's column on shift.
// ---------------------------------------------------------------------------
module sai2x_col_cell
   import sai2x_pkg::*;
(
   input  logic       clock,
   input  logic       shift,
   input  column_type next_col,
   output column_type col_q
);

   column_type col_ff;
   column_type col_in;

   always_comb begin
      col_in = shift ? next_col : col_ff;
   end

   always_ff @(posedge clock) begin
      col_ff <= col_in;
   end

   assign col_q = col_ff;

endmodule

// ===== rtl/core/sai2x_kernel.sv =====
// ---------------------------------------------------------------------------
// sai2x_kernel
// Edge tests, vote and blends producing the 2x2 block for the center pixel.
// ---------------------------------------------------------------------------
module sai2x_kernel
   import sai2x_pkg::*;
(
   input  logic       fmt,
   input  column_type col0,
   input  column_type col1,
   input  column_type col2,
   input  column_type col3,
   output quad_type   quad
);

   logic [15:0] c1, c2, c3, c4, c5, c6, s1, s2;
   logic [15:0] a0, a1, a2, a3, b0, b1, b2, b3;
   logic        e26, e53;
   logic signed [3:0] vote_sum;
   logic signed [1:0] v0, v1, v2, v3;
   logic [15:0] p1a, p1b, p2a, p2b;

   assign c4 = col0.upper;
   assign c5 = col1.upper;
   assign c6 = col2.upper;
   assign s2 = col3.upper;
   assign c1 = col0.lower;
   assign c2 = col1.lower;
   assign c3 = col2.lower;
   assign s1 = col3.lower;
   assign a0 = col0.below;
   assign a1 = col1.below;
   assign a2 = col2.below;
   assign a3 = col3.below;
   assign b0 = col0.above;
   assign b1 = col1.above;
   assign b2 = col2.above;
   assign b3 = col3.above;

   assign e26 = (c2 == c6);
   assign e53 = (c5 == c3);

   assign v0 = vote(c6, c5, c1, a1);
   assign v1 = vote(c6, c5, c4, b1);
   assign v2 = vote(c6, c5, a2, s1);
   assign v3 = vote(c6, c5, b2, s2);
   assign vote_sum = {{2{v0[1]}}, v0} + {{2{v1[1]}}, v1}
                   + {{2{v2[1]}}, v2} + {{2{v3[1]}}, v3};

   always_comb begin
      p1b = avg2(fmt, c5, c6);
      p2b = avg2(fmt, c2, c3);
      if (e26 && !e53) begin
         p1b = c2;
         p2b = c2;
      end else if (e53 && !e26) begin
         p1b = c5;
         p2b = c5;
      end else if (e53 && e26) begin
         if (vote_sum > 4'sd0) begin
            p1b = c6;
            p2b = c6;
         end else if (vote_sum < 4'sd0) begin
            p1b = c5;
            p2b = c5;
         end else begin
            p1b = avg2(fmt, c5, c6);
            p2b = p1b;
         end
      end else begin
         if (c6 == c3 && c3 == a1 && c2 != a2 && c3 != a0) begin
            p2b = avg4(fmt, c3, c3, c3, c2);
         end else if (c5 == c2 && c2 == a2 && a1 != c3 && c2 != a3) begin
            p2b = avg4(fmt, c2, c2, c2, c3);
         end
         if (c6 == c3 && c6 == b1 && c5 != b2 && c6 != b0) begin
            p1b = avg4(fmt, c6, c6, c6, c5);
         end else if (c5 == c2 && c5 == b2 && b1 != c6 && c5 != b3) begin
            p1b = avg4(fmt, c6, c5, c5, c5);
         end
      end

      if (e53 && !e26 && c4 == c5 && c5 != a2) begin
         p2a = avg2(fmt, c2, c5);
      end else if (c5 == c1 && c6 == c5 && c4 != c2 && c5 != a0) begin
         p2a = avg2(fmt, c2, c5);
      end else begin
         p2a = c2;
      end

      if (e26 && !e53 && c1 == c2 && c2 != b2) begin
         p1a = avg2(fmt, c2, c5);
      end else if (c4 == c2 && c3 == c2 && c1 != c5 && c2 != b0) begin
         p1a = avg2(fmt, c2, c5);
      end else begin
         p1a = c5;
      end
   end

   assign quad.top_left     = p1a;
   assign quad.top_right    = p1b;
   assign quad.bottom_left  = p2a;
   assign quad.bottom_right = p2b;

endmodule
